### rtl/core/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the utf-8 sequence decoder
// no dependencies; used by utf8d_out_if and every module in rtl/core

package utf8d_pkg;

	localparam int MAX_LEN   = 6;
	localparam int NUM_LANES = MAX_LEN - 1;

	localparam logic [7:0] LEAD_INVALID = 8'hFE;
	localparam logic [7:0] LEAD_LEN6    = 8'hFC;
	localparam logic [7:0] LEAD_LEN5    = 8'hF8;
	localparam logic [7:0] LEAD_LEN4    = 8'hF0;
	localparam logic [7:0] LEAD_LEN3    = 8'hE0;
	localparam logic [7:0] LEAD_LEN2    = 8'hC0;
	localparam logic [7:0] LEAD_CONT    = 8'h80;
	localparam logic [1:0] CONT_TAG     = 2'b10;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_ROOM = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// one continuation lane: form check plus its six payload bits
	typedef struct packed {
		logic       ok;
		logic [5:0] bits;
	} lane_t;

	// lead byte decode: length, masked payload bits, bad-lead flag
	typedef struct packed {
		logic       bad;
		logic [2:0] len;
		logic [6:0] bits;
	} lead_t;

endpackage

### rtl/core/utf8d_in_if.sv
// utf8d_in_if: valid/ready channel carrying one byte sequence word
// depends on utf8d_pkg only through its users

interface utf8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_0;
	logic [7:0] byte_1;
	logic [7:0] byte_2;
	logic [7:0] byte_3;
	logic [7:0] byte_4;
	logic [7:0] byte_5;
	logic [2:0] bytes_available;

	modport source (
		output valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, bytes_available,
		input  ready
	);
	modport sink (
		input  valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, bytes_available,
		output ready
	);
endinterface

### rtl/core/utf8d_out_if.sv
// utf8d_out_if: valid/ready channel carrying one decode result word
// depends on utf8d_pkg for the status type

interface utf8d_out_if;
	logic               valid;
	logic               ready;
	utf8d_pkg::status_t status;
	logic [30:0]        code_point;
	logic [2:0]         consumed;

	modport source (
		output valid, status, code_point, consumed,
		input  ready
	);
	modport sink (
		input  valid, status, code_point, consumed,
		output ready
	);
endinterface

### rtl/core/utf8d_lane.sv
// utf8d_lane: checks one continuation byte and extracts its payload bits
// depends on utf8d_pkg

module utf8d_lane (
	input  logic [7:0]       cont_byte,
	output utf8d_pkg::lane_t lane
);
	assign lane.ok   = (cont_byte[7:6] == utf8d_pkg::CONT_TAG);
	assign lane.bits = cont_byte[5:0];
endmodule

### rtl/core/utf8d_lead.sv
// utf8d_lead: decodes the lead byte into sequence length and payload bits
// depends on utf8d_pkg

module utf8d_lead (
	input  logic [7:0]       lead_byte,
	output utf8d_pkg::lead_t lead
);
	always_comb begin
		lead = '0;
		if (lead_byte >= utf8d_pkg::LEAD_INVALID) begin
			lead.bad = 1'b1;
		end else if (lead_byte >= utf8d_pkg::LEAD_LEN6) begin
			lead.len  = 3'd6;
			lead.bits = {6'b0, lead_byte[0]};
		end else if (lead_byte >= utf8d_pkg::LEAD_LEN5) begin
			lead.len  = 3'd5;
			lead.bits = {5'b0, lead_byte[1:0]};
		end else if (lead_byte >= utf8d_pkg::LEAD_LEN4) begin
			lead.len  = 3'd4;
			lead.bits = {4'b0, lead_byte[2:0]};
		end else if (lead_byte >= utf8d_pkg::LEAD_LEN3) begin
			lead.len  = 3'd3;
			lead.bits = {3'b0, lead_byte[3:0]};
		end else if (lead_byte >= utf8d_pkg::LEAD_LEN2) begin
			lead.len  = 3'd2;
			lead.bits = {2'b0, lead_byte[4:0]};
		end else if (lead_byte >= utf8d_pkg::LEAD_CONT) begin
			// stray continuation byte in lead position
			lead.bad = 1'b1;
		end else begin
			lead.len  = 3'd1;
			lead.bits = lead_byte[6:0];
		end
	end
endmodule

### rtl/core/utf8d_merge.sv
// utf8d_merge: combines lead decode and lane results into status and code point
// depends on utf8d_pkg

module utf8d_merge (
	input  utf8d_pkg::lead_t   lead,
	input  utf8d_pkg::lane_t   lanes [utf8d_pkg::NUM_LANES],
	input  logic [2:0]         avail,
	output utf8d_pkg::status_t status,
	output logic [30:0]        code_point,
	output logic [2:0]         consumed
);
	logic        cont_bad;
	logic [30:0] cp_full;

	always_comb begin
		cont_bad = 1'b0;
		// only bytes inside the sequence length count
		for (int i = 0; i < utf8d_pkg::NUM_LANES; i++) begin
			if (3'(i + 1) < lead.len && !lanes[i].ok)
				cont_bad = 1'b1;
		end
	end

	always_comb begin
		case (lead.len)
			3'd2:    cp_full = {20'b0, lead.bits[4:0], lanes[0].bits};
			3'd3:    cp_full = {15'b0, lead.bits[3:0], lanes[0].bits, lanes[1].bits};
			3'd4:    cp_full = {10'b0, lead.bits[2:0], lanes[0].bits, lanes[1].bits,
				lanes[2].bits};
			3'd5:    cp_full = {5'b0, lead.bits[1:0], lanes[0].bits, lanes[1].bits,
				lanes[2].bits, lanes[3].bits};
			3'd6:    cp_full = {lead.bits[0], lanes[0].bits, lanes[1].bits,
				lanes[2].bits, lanes[3].bits, lanes[4].bits};
			default: cp_full = {24'b0, lead.bits};
		endcase
	end

	always_comb begin
		status     = utf8d_pkg::ST_OK;
		code_point = cp_full;
		consumed   = lead.len;
		if (avail == 3'd0) begin
			status = utf8d_pkg::ST_NO_ROOM;
		end else if (lead.bad) begin
			status = utf8d_pkg::ST_INVALID;
		end else if (lead.len > avail) begin
			status = utf8d_pkg::ST_NO_ROOM;
		end else if (cont_bad) begin
			status = utf8d_pkg::ST_INVALID;
		end
		if (status != utf8d_pkg::ST_OK) begin
			code_point = '0;
			consumed   = '0;
		end
	end
endmodule

### rtl/core/utf8_sequence_decoder.sv
// utf8_sequence_decoder: top level, lane pipeline for one utf-8 sequence per word
// depends on utf8d_pkg, utf8d_in_if, utf8d_out_if, utf8d_lane, utf8d_lead, utf8d_merge
//
//   channel | dir | payload
//   seq     | in  | byte_0..byte_5, bytes_available
//   res     | out | status, code_point, consumed
//
// one word per cycle sustained while res.ready is high
// stage 1 registers the lead decode and the five continuation lanes, stage 2 the merge
// arst_n clears both valid flags; payload registers are not reset
// a stalled result holds in stage 2 while stage 1 still takes a new word only if it is empty

module utf8_sequence_decoder (
	input logic         clk,
	input logic         arst_n,
	utf8d_in_if.sink    seq,
	utf8d_out_if.source res
);
	logic [7:0]        cont_byte [utf8d_pkg::NUM_LANES];
	utf8d_pkg::lane_t  lane_c [utf8d_pkg::NUM_LANES];
	utf8d_pkg::lane_t  lane_s1 [utf8d_pkg::NUM_LANES];
	utf8d_pkg::lead_t  lead_c;
	utf8d_pkg::lead_t  lead_s1;
	logic [2:0]        avail_s1;
	logic              valid_s1;
	logic              adv_s1;

	utf8d_pkg::status_t status_c;
	logic [30:0]        cp_c;
	logic [2:0]         consumed_c;
	utf8d_pkg::status_t status_s2;
	logic [30:0]        cp_s2;
	logic [2:0]         consumed_s2;
	logic               valid_s2;

	assign cont_byte[0] = seq.byte_1;
	assign cont_byte[1] = seq.byte_2;
	assign cont_byte[2] = seq.byte_3;
	assign cont_byte[3] = seq.byte_4;
	assign cont_byte[4] = seq.byte_5;

	for (genvar g = 0; g < utf8d_pkg::NUM_LANES; g++) begin : g_lane
		utf8d_lane u_lane (
			.cont_byte (cont_byte[g]),
			.lane      (lane_c[g])
		);
	end

	utf8d_lead u_lead (
		.lead_byte (seq.byte_0),
		.lead      (lead_c)
	);

	assign adv_s1    = !valid_s2 || res.ready;
	assign seq.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seq.ready) begin
			valid_s1 <= seq.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq.ready && seq.valid) begin
			lane_s1  <= lane_c;
			lead_s1  <= lead_c;
			// counts above six act as six
			avail_s1 <= (seq.bytes_available > 3'd6) ? 3'd6 : seq.bytes_available;
		end
	end

	utf8d_merge u_merge (
		.lead       (lead_s1),
		.lanes      (lane_s1),
		.avail      (avail_s1),
		.status     (status_c),
		.code_point (cp_c),
		.consumed   (consumed_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			status_s2   <= status_c;
			cp_s2       <= cp_c;
			consumed_s2 <= consumed_c;
		end
	end

	assign res.valid      = valid_s2;
	assign res.status     = status_s2;
	assign res.code_point = cp_s2;
	assign res.consumed   = consumed_s2;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		seq.valid && seq.ready |=> valid_s1)
		else $error("accepted word did not reach stage 1");

	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != utf8d_pkg::ST_OK |-> res.code_point == '0 && res.consumed == '0)
		else $error("error result carries nonzero payload");

	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == utf8d_pkg::ST_OK |-> res.consumed != 3'd0 && res.consumed <= 3'd6)
		else $error("ok result with bad consumed count");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res.ready |=> valid_s2 && $stable(cp_s2))
		else $error("stalled result lost or changed");
endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for utf8_sequence_decoder, directed table then random words
// depends on utf8d_pkg, utf8d_in_if, utf8d_out_if and the decoder rtl

module tb_top;
	import utf8d_pkg::*;

	localparam int RANDOM_WORDS = 1850;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [0:5][7:0] bytes;
		logic [2:0]      avail;
	} seq_word_t;

	typedef struct packed {
		status_t     status;
		logic [30:0] code_point;
		logic [2:0]  consumed;
	} decode_t;

	typedef struct packed {
		seq_word_t word;
		bit        typed;
		decode_t   want;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;

	utf8d_in_if  seq_if ();
	utf8d_out_if res_if ();

	utf8_sequence_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seq    (seq_if),
		.res    (res_if)
	);

	table_row_t directed_rows[$];
	decode_t    pending_decodes[$];
	int         mismatch_count = 0;
	int         result_count   = 0;
	int         cycle_count    = 0;
	int         stall_left     = 0;
	bit         calm           = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// independent decode of one sequence word
	function automatic decode_t decode_sequence(seq_word_t w);
		decode_t     d;
		int unsigned avail;
		int unsigned len;
		logic [30:0] cp;
		logic [7:0]  lead;
		d.status     = ST_OK;
		d.code_point = '0;
		d.consumed   = '0;
		avail = (w.avail > 3'd6) ? 6 : w.avail;
		lead  = w.bytes[0];
		cp    = '0;
		len   = 0;
		if (avail == 0) begin
			d.status = ST_NO_ROOM;
			return d;
		end
		if (lead >= LEAD_INVALID) begin
			d.status = ST_INVALID;
			return d;
		end else if (lead >= LEAD_LEN6) begin
			len = 6; cp = 31'(lead[0]);
		end else if (lead >= LEAD_LEN5) begin
			len = 5; cp = 31'(lead[1:0]);
		end else if (lead >= LEAD_LEN4) begin
			len = 4; cp = 31'(lead[2:0]);
		end else if (lead >= LEAD_LEN3) begin
			len = 3; cp = 31'(lead[3:0]);
		end else if (lead >= LEAD_LEN2) begin
			len = 2; cp = 31'(lead[4:0]);
		end else if (lead >= LEAD_CONT) begin
			d.status = ST_INVALID;
			return d;
		end else begin
			len = 1; cp = 31'(lead);
		end
		if (len > avail) begin
			d.status = ST_NO_ROOM;
			return d;
		end
		for (int i = 1; i < len; i++) begin
			if (w.bytes[i][7:6] != CONT_TAG) begin
				d.status = ST_INVALID;
				return d;
			end
			cp = {cp[24:0], w.bytes[i][5:0]};
		end
		d.code_point = cp;
		d.consumed   = 3'(len);
		return d;
	endfunction

	function automatic void add_row(logic [47:0] seq, logic [2:0] avail, bit typed = 1'b0,
			status_t st = ST_OK, logic [30:0] cp = '0, logic [2:0] used = '0);
		table_row_t row;
		row.word.bytes      = seq;
		row.word.avail      = avail;
		row.typed           = typed;
		row.want.status     = st;
		row.want.code_point = cp;
		row.want.consumed   = used;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// well-formed sequences with random payload, plus short, broken and noise words
	function automatic seq_word_t make_word();
		seq_word_t   w;
		int          r;
		int unsigned len;
		int unsigned pos;
		int          bad;
		r = $urandom_range(0, 99);
		w.bytes = {$urandom, 16'($urandom)};
		w.avail = 3'($urandom_range(0, 7));
		if (r < 25)
			return w;
		len = $urandom_range(1, 6);
		case (len)
			1: w.bytes[0] = 8'($urandom_range(0, 127));
			2: w.bytes[0] = LEAD_LEN2 | 8'($urandom_range(0, 31));
			3: w.bytes[0] = LEAD_LEN3 | 8'($urandom_range(0, 15));
			4: w.bytes[0] = LEAD_LEN4 | 8'($urandom_range(0, 7));
			5: w.bytes[0] = LEAD_LEN5 | 8'($urandom_range(0, 3));
			default: w.bytes[0] = LEAD_LEN6 | 8'($urandom_range(0, 1));
		endcase
		for (int i = 1; i < len; i++)
			w.bytes[i] = {CONT_TAG, 6'($urandom)};
		if (r < 40) begin
			w.avail = 3'($urandom_range(0, len - 1));
		end else begin
			w.avail = 3'($urandom_range(len, 7));
			if (r < 52 && len > 1) begin
				pos = $urandom_range(1, len - 1);
				bad = $urandom_range(0, 2);
				w.bytes[pos][7:6] = (bad == 2) ? 2'b11 : 2'(bad);
			end
		end
		return w;
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("[%0t] result %0d: %s", $realtime, result_count, what);
	endtask

	task automatic send_word(seq_word_t w, decode_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			seq_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seq_if.valid           <= 1'b1;
		seq_if.byte_0          <= w.bytes[0];
		seq_if.byte_1          <= w.bytes[1];
		seq_if.byte_2          <= w.bytes[2];
		seq_if.byte_3          <= w.bytes[3];
		seq_if.byte_4          <= w.bytes[4];
		seq_if.byte_5          <= w.bytes[5];
		seq_if.bytes_available <= w.avail;
		do
			@(posedge clk);
		while (!seq_if.ready);
		pending_decodes.insert(pending_decodes.size(), want);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		int n;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_if.ready <= 1'b0;
		end else begin
			n = pick_gap();
			if (n == 0) begin
				res_if.ready <= 1'b1;
			end else begin
				stall_left = n - 1;
				res_if.ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		decode_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_decodes.size() == 0) begin
				report_mismatch("result word with no decode pending");
			end else begin
				want = pending_decodes.pop_front();
				if (res_if.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						res_if.status, want.status));
				if (res_if.code_point !== want.code_point)
					report_mismatch($sformatf("code_point got %h want %h",
						res_if.code_point, want.code_point));
				if (res_if.consumed !== want.consumed)
					report_mismatch($sformatf("consumed got %0d want %0d",
						res_if.consumed, want.consumed));
			end
			result_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		seq_word_t w;
		arst_n                 = 1'b0;
		seq_if.valid           = 1'b0;
		seq_if.byte_0          = '0;
		seq_if.byte_1          = '0;
		seq_if.byte_2          = '0;
		seq_if.byte_3          = '0;
		seq_if.byte_4          = '0;
		seq_if.byte_5          = '0;
		seq_if.bytes_available = '0;
		res_if.ready           = 1'b0;

		add_row(48'h41_00_00_00_00_00, 3'd0, 1'b1, ST_NO_ROOM);
		add_row(48'h00_FF_FF_FF_FF_FF, 3'd1, 1'b1, ST_OK, 31'h0, 3'd1);
		add_row(48'h7F_80_80_80_80_80, 3'd6, 1'b1, ST_OK, 31'h7F, 3'd1);
		add_row(48'h80_80_80_80_80_80, 3'd6, 1'b1, ST_INVALID);
		add_row(48'hBF_BF_BF_BF_BF_BF, 3'd6, 1'b1, ST_INVALID);
		add_row(48'hFE_BF_BF_BF_BF_BF, 3'd6, 1'b1, ST_INVALID);
		// empty buffer wins over a bad lead
		add_row(48'hFF_BF_BF_BF_BF_BF, 3'd0, 1'b1, ST_NO_ROOM);
		add_row(48'hFF_00_00_00_00_00, 3'd1, 1'b1, ST_INVALID);
		add_row(48'hC2_A9_00_00_00_00, 3'd2);
		add_row(48'hC0_80_00_00_00_00, 3'd1, 1'b1, ST_NO_ROOM);
		add_row(48'hDF_BF_FF_FF_FF_FF, 3'd7);
		add_row(48'hE2_82_AC_00_00_00, 3'd3);
		add_row(48'hED_A0_80_00_00_00, 3'd3);
		add_row(48'hF0_9F_98_80_00_00, 3'd4);
		add_row(48'hF7_BF_BF_BF_00_00, 3'd4);
		add_row(48'hF8_88_80_80_80_00, 3'd5);
		add_row(48'hFB_BF_BF_BF_BF_00, 3'd6);
		add_row(48'hFC_84_80_80_80_80, 3'd6);
		add_row(48'hFD_BF_BF_BF_BF_BF, 3'd7, 1'b1, ST_OK, 31'h7FFF_FFFF, 3'd6);
		add_row(48'hFD_BF_BF_BF_BF_BF, 3'd5, 1'b1, ST_NO_ROOM);
		add_row(48'hC3_28_00_00_00_00, 3'd2, 1'b1, ST_INVALID);
		add_row(48'hE2_82_C0_00_00_00, 3'd3, 1'b1, ST_INVALID);
		add_row(48'hFC_80_80_80_80_7F, 3'd6, 1'b1, ST_INVALID);
		// overlong zero passes through
		add_row(48'hC0_80_00_00_00_00, 3'd2, 1'b1, ST_OK, 31'h0, 3'd2);
		// short buffer hides a bad continuation byte
		add_row(48'hF0_FF_FF_FF_00_00, 3'd3, 1'b1, ST_NO_ROOM);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed ?
				directed_rows[i].want : decode_sequence(directed_rows[i].word));

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			calm = ((n / 150) % 4 == 2);
			w = make_word();
			send_word(w, decode_sequence(w));
		end
		calm = 1'b0;
		seq_if.valid <= 1'b0;

		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_in_if.sv
rtl/core/utf8d_out_if.sv
rtl/core/utf8d_lane.sv
rtl/core/utf8d_lead.sv
rtl/core/utf8d_merge.sv
rtl/core/utf8_sequence_decoder.sv
verif/tb_top.sv
